/* hdl/direct_mapped_write_back_cache_core_assert.svh */
// Assertion macros used by the cache core top level.
`ifndef DIRECT_MAPPED_WRITE_BACK_CACHE_CORE_ASSERT_SVH
`define DIRECT_MAPPED_WRITE_BACK_CACHE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication check.
`define DMC_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cache core implication check failed");

// Next-cycle implication check.
`define DMC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cache core next-cycle check failed");

`else

`define DMC_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define DMC_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

/* hdl/dmc_pkg.sv */
// Types, constants and helpers shared by the cache core modules.
`timescale 1ns / 1ps
package dmc_pkg;

   localparam int LINES        = 32;
   localparam int INDEX_BITS   = $clog2(LINES);
   localparam int ADDRESS_BITS = 16;
   localparam int WORD_BITS    = 16;
   localparam int COUNT_BITS   = 32;

   typedef logic [ADDRESS_BITS-1:0] addr_type;
   typedef logic [WORD_BITS-1:0]    word_type;
   typedef logic [INDEX_BITS-1:0]   index_type;
   typedef logic [COUNT_BITS-1:0]   count_type;

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_COMPARE
   } state_type;

   typedef struct packed {
      op_type   op;
      addr_type address;
      word_type write_value;
      word_type backing_word;
   } req_type;

   typedef struct packed {
      word_type  read_data;
      logic      hit;
      logic      memory_read;
      logic      writeback_valid;
      addr_type  writeback_address;
      word_type  writeback_data;
      count_type hit_total;
      count_type miss_total;
      count_type memory_read_total;
      count_type memory_write_total;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic lookup;
      logic commit;
      logic inc_hit;
      logic inc_miss;
      logic inc_wb;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_write;
      logic hit;
      logic evict;
   } stat_type;

   // Line index is the low bits of (all-ones minus address), i.e. of its inverse.
   function automatic index_type line_index(addr_type address);
      addr_type inv;
      inv = ~address;
      return inv[INDEX_BITS-1:0];
   endfunction

   // Tag that a line holds after reset: all-ones minus the line number.
   function automatic addr_type reset_tag(index_type idx);
      return ~addr_type'(idx);
   endfunction

endpackage

/* hdl/direct_mapped_write_back_cache_core.sv */
// Top level of the direct-mapped write-back cache core.
`timescale 1ns / 1ps
// A transaction is taken when start is high and busy is low. The addressed line is read
// into registers at the accepting edge, and busy stays high for the one compare-and-update
// cycle that follows, so no new transaction is taken until that cycle ends. The result is
// presented on rsp_item with rsp_valid high for exactly one cycle, starting at the edge that
// ends the compare-and-update cycle; the receiver must take it then. Lines come out of reset
// already holding their reset contents (per-line valid flags), so no clearing pass is needed
// and the first transaction may start right after reset.
module direct_mapped_write_back_cache_core
   import dmc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

`include "direct_mapped_write_back_cache_core_assert.svh"

   cmd_type  cmd;
   stat_type stat;

   dmc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   dmc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // A result always follows the busy cycle of its transaction.
   `DMC_ASSERT_IMPLY(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy))
   // An accepted transaction makes the block busy in the next cycle.
   `DMC_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // A hit never evicts a line and never reads memory.
   `DMC_ASSERT_IMPLY(a_hit_no_wb, clock, reset, rsp_valid && rsp_item.hit,
      !rsp_item.writeback_valid && !rsp_item.memory_read)
   // A reported writeback has already been counted in the writeback total.
   `DMC_ASSERT_IMPLY(a_wb_counted, clock, reset, rsp_valid && rsp_item.writeback_valid,
      rsp_item.memory_write_total != 32'd0 || $past(rsp_item.memory_write_total, 2) != 32'd0)

endmodule

/* hdl/dmc_ctrl.sv */
// Controller state machine of the cache core.
`timescale 1ns / 1ps
module dmc_ctrl
   import dmc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output logic     busy,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy = 1'b0;
      cmd  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.lookup = start;
         end
         ST_COMPARE: begin
            busy         = 1'b1;
            cmd.commit   = 1'b1;
            cmd.inc_hit  = !stat.is_write && stat.hit;
            cmd.inc_miss = !stat.is_write && !stat.hit;
            cmd.inc_wb   = stat.evict;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

endmodule

/* hdl/dmc_datapath.sv */
// Datapath of the cache core: line storage, compare, counters and result register.
`timescale 1ns / 1ps
module dmc_datapath
   import dmc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_item,
   input  cmd_type  cmd,
   output stat_type stat,
   output logic     rsp_valid,
   output rsp_type  rsp_item
);

   word_type  data_mem [LINES];
   addr_type  tag_mem  [LINES];
   logic      dirty_mem [LINES];

   logic [LINES-1:0] line_valid_ff;

   req_type   req_ff;
   index_type idx_ff;
   word_type  rd_data_ff;
   addr_type  rd_tag_ff;
   logic      rd_dirty_ff;
   logic      rd_valid_ff;

   count_type hit_cnt_ff;
   count_type miss_cnt_ff;
   count_type wb_cnt_ff;
   count_type hit_cnt_in;
   count_type miss_cnt_in;
   count_type wb_cnt_in;

   logic      rsp_valid_ff;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;

   word_type  cur_data;
   addr_type  cur_tag;
   logic      cur_dirty;
   logic      is_write;
   logic      hit;
   logic      evict;
   logic      line_we;
   word_type  new_data;

   // Lookup: latch the transaction and read the addressed line.
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         req_ff      <= req_item;
         idx_ff      <= line_index(req_item.address);
         rd_data_ff  <= data_mem[line_index(req_item.address)];
         rd_tag_ff   <= tag_mem[line_index(req_item.address)];
         rd_dirty_ff <= dirty_mem[line_index(req_item.address)];
         rd_valid_ff <= line_valid_ff[line_index(req_item.address)];
      end
   end

   // A line never written since reset reads as its reset contents.
   always_comb begin
      cur_data  = rd_valid_ff ? rd_data_ff  : '0;
      cur_tag   = rd_valid_ff ? rd_tag_ff   : reset_tag(idx_ff);
      cur_dirty = rd_valid_ff ? rd_dirty_ff : 1'b1;
      is_write  = (req_ff.op == OP_WRITE);
      hit       = (cur_tag == req_ff.address);
      evict     = !hit && cur_dirty;
      line_we   = is_write || !hit;
      new_data  = is_write ? req_ff.write_value : req_ff.backing_word;
   end

   assign stat.is_write = is_write;
   assign stat.hit      = hit;
   assign stat.evict    = evict;

   always_ff @(posedge clock) begin
      if (cmd.commit && line_we) begin
         data_mem[idx_ff]  <= new_data;
         tag_mem[idx_ff]   <= req_ff.address;
         dirty_mem[idx_ff] <= is_write;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_valid_ff <= '0;
      end else if (cmd.commit && line_we) begin
         line_valid_ff[idx_ff] <= 1'b1;
      end
   end

   // Read misses and memory reads always move together, so one counter serves both.
   always_comb begin
      hit_cnt_in  = hit_cnt_ff  + count_type'(cmd.inc_hit);
      miss_cnt_in = miss_cnt_ff + count_type'(cmd.inc_miss);
      wb_cnt_in   = wb_cnt_ff   + count_type'(cmd.inc_wb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_cnt_ff  <= '0;
         miss_cnt_ff <= '0;
         wb_cnt_ff   <= '0;
      end else begin
         hit_cnt_ff  <= hit_cnt_in;
         miss_cnt_ff <= miss_cnt_in;
         wb_cnt_ff   <= wb_cnt_in;
      end
   end

   always_comb begin
      rsp_in.read_data          = is_write ? '0 : (hit ? cur_data : req_ff.backing_word);
      rsp_in.hit                = hit;
      rsp_in.memory_read        = !is_write && !hit;
      rsp_in.writeback_valid    = evict;
      rsp_in.writeback_address  = evict ? cur_tag : '0;
      rsp_in.writeback_data     = evict ? cur_data : '0;
      rsp_in.hit_total          = hit_cnt_in;
      rsp_in.miss_total         = miss_cnt_in;
      rsp_in.memory_read_total  = miss_cnt_in;
      rsp_in.memory_write_total = wb_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

/* tb/direct_mapped_write_back_cache_core_test.sv */
// Self-checking testbench for the direct-mapped write-back cache core.
`timescale 1ns / 1ps
module direct_mapped_write_back_cache_core_test;
   import dmc_pkg::*;

   localparam int STALL_LIMIT     = 1000;
   localparam int RANDOM_ACCESSES = 800;
   localparam int SETTLE_CYCLES   = 4;
   localparam addr_type ADDR_ONES = '1;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } access_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;

   // Shadow copy of the cache contents and its statistics.
   word_type  shadow_data [LINES];
   addr_type  shadow_tag [LINES];
   bit        shadow_dirty [LINES];
   count_type hits_seen;
   count_type misses_seen;
   count_type fills_seen;
   count_type writebacks_seen;

   rsp_type results_due[$];
   int      failures = 0;
   bit      timed_out = 1'b0;
   bit      steady_flow = 1'b0;

   always #5 clock = ~clock;

   direct_mapped_write_back_cache_core u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   task automatic reset_shadow();
      for (int i = 0; i < LINES; i++) begin
         shadow_data[i]  = '0;
         shadow_tag[i]   = ADDR_ONES - addr_type'(i);
         shadow_dirty[i] = 1'b1;
      end
      hits_seen       = '0;
      misses_seen     = '0;
      fills_seen      = '0;
      writebacks_seen = '0;
   endtask

   // Applies one access to the shadow cache and returns the response it should produce.
   function automatic rsp_type apply_access(req_type a);
      index_type idx;
      rsp_type   r;
      logic      tag_match;
      idx = index_type'(ADDR_ONES - a.address);
      r = '0;
      tag_match = (shadow_tag[idx] == a.address);
      r.hit = tag_match;
      if (!tag_match && shadow_dirty[idx]) begin
         r.writeback_valid   = 1'b1;
         r.writeback_address = shadow_tag[idx];
         r.writeback_data    = shadow_data[idx];
         writebacks_seen += 1;
      end
      if (a.op == OP_READ) begin
         if (tag_match) begin
            r.read_data = shadow_data[idx];
            hits_seen += 1;
         end else begin
            misses_seen += 1;
            fills_seen  += 1;
            r.memory_read     = 1'b1;
            r.read_data       = a.backing_word;
            shadow_data[idx]  = a.backing_word;
            shadow_tag[idx]   = a.address;
            shadow_dirty[idx] = 1'b0;
         end
      end else begin
         shadow_data[idx]  = a.write_value;
         shadow_tag[idx]   = a.address;
         shadow_dirty[idx] = 1'b1;
      end
      r.hit_total          = hits_seen;
      r.miss_total         = misses_seen;
      r.memory_read_total  = fills_seen;
      r.memory_write_total = writebacks_seen;
      return r;
   endfunction

   function automatic access_row_type plain(op_type op, addr_type a, word_type wv,
                                            word_type bw);
      access_row_type r;
      r.item.op           = op;
      r.item.address      = a;
      r.item.write_value  = wv;
      r.item.backing_word = bw;
      r.typed             = 1'b0;
      r.want              = '0;
      return r;
   endfunction

   function automatic access_row_type checked(access_row_type r, rsp_type w);
      access_row_type c;
      c       = r;
      c.typed = 1'b1;
      c.want  = w;
      return c;
   endfunction

   function automatic rsp_type outcome(word_type rd, logic h, logic mr, logic wb,
                                       addr_type wba, word_type wbd, count_type ht,
                                       count_type mt, count_type rt, count_type wt);
      rsp_type r;
      r.read_data          = rd;
      r.hit                = h;
      r.memory_read        = mr;
      r.writeback_valid    = wb;
      r.writeback_address  = wba;
      r.writeback_data     = wbd;
      r.hit_total          = ht;
      r.miss_total         = mt;
      r.memory_read_total  = rt;
      r.memory_write_total = wt;
      return r;
   endfunction

   function automatic int draw_gap();
      return steady_flow ? 0 : int'($urandom_range(0, 19));
   endfunction

   // Mostly a small set of tags so that lines are hit, refilled and evicted often.
   function automatic addr_type pick_address();
      logic [10:0] upper;
      if ($urandom_range(0, 9) < 6) begin
         case ($urandom_range(0, 3))
            0: upper = 11'h000;
            1: upper = 11'h7FF;
            2: upper = 11'h555;
            default: upper = 11'h2AA;
         endcase
         return {upper, 5'($urandom_range(0, 31))};
      end
      return addr_type'($urandom_range(0, 65535));
   endfunction

   task automatic issue_access(input req_type item, input bit typed, input rsp_type want,
                               input int gap);
      rsp_type predicted;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = apply_access(item);
      results_due.push_back(typed ? want : predicted);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
   endtask

   task automatic run_accesses();
      access_row_type script[$];
      req_type        item;
      // After reset line 0 holds the all-ones address, so the first read hits.
      script.push_back(checked(plain(OP_READ, 16'hFFFF, 16'h0000, 16'h1234),
                               outcome(16'h0000, 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000,
                                       1, 0, 0, 0)));
      script.push_back(checked(plain(OP_WRITE, 16'hFFFF, 16'hFFFF, 16'h0000),
                               outcome(16'h0000, 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000,
                                       1, 0, 0, 0)));
      script.push_back(checked(plain(OP_READ, 16'h0000, 16'h0000, 16'hFFFF),
                               outcome(16'hFFFF, 1'b0, 1'b1, 1'b1, 16'hFFE0, 16'h0000,
                                       1, 1, 1, 1)));
      script.push_back(checked(plain(OP_READ, 16'h0000, 16'hFFFF, 16'h0000),
                               outcome(16'hFFFF, 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000,
                                       2, 1, 1, 1)));
      // A write miss over a clean line neither fills nor writes back.
      script.push_back(checked(plain(OP_WRITE, 16'h0020, 16'hA5A5, 16'h0000),
                               outcome(16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000,
                                       2, 1, 1, 1)));
      script.push_back(checked(plain(OP_READ, 16'h0000, 16'h0000, 16'h5555),
                               outcome(16'h5555, 1'b0, 1'b1, 1'b1, 16'h0020, 16'hA5A5,
                                       2, 2, 2, 2)));
      script.push_back(plain(OP_WRITE, 16'hFFE0, 16'h8001, 16'hFFFF));
      script.push_back(plain(OP_READ,  16'hFFE0, 16'h0000, 16'h0000));
      script.push_back(plain(OP_WRITE, 16'hFFE0, 16'h0000, 16'h0000));
      script.push_back(plain(OP_READ,  16'h7FFF, 16'hFFFF, 16'h8000));
      script.push_back(plain(OP_READ,  16'h7FFF, 16'h0000, 16'hAAAA));
      script.push_back(plain(OP_WRITE, 16'h8000, 16'h5555, 16'h0000));
      script.push_back(plain(OP_READ,  16'hFFE1, 16'h0000, 16'h0000));
      script.push_back(plain(OP_READ,  16'hAAAA, 16'hAAAA, 16'h5555));
      script.push_back(plain(OP_WRITE, 16'h5555, 16'hAAAA, 16'h0000));
      script.push_back(plain(OP_READ,  16'h5555, 16'h0000, 16'h0000));
      script.push_back(plain(OP_WRITE, 16'h5555, 16'h1111, 16'h0000));
      script.push_back(plain(OP_READ,  16'h5555, 16'h0000, 16'hFFFF));
      script.push_back(plain(OP_READ,  16'h1234, 16'h0000, 16'h4321));
      script.push_back(plain(OP_READ,  16'h1234, 16'h0000, 16'h0000));

      steady_flow = ($urandom_range(0, 1) == 0);
      foreach (script[i]) issue_access(script[i].item, script[i].typed, script[i].want,
                                       draw_gap());
      drain_results();

      for (int n = 0; n < RANDOM_ACCESSES; n++) begin
         if (n % 50 == 0) steady_flow = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_ACCESSES / 2) drain_results();
         item.op           = ($urandom_range(0, 1) == 1) ? OP_WRITE : OP_READ;
         item.address      = pick_address();
         item.write_value  = word_type'($urandom);
         item.backing_word = word_type'($urandom);
         issue_access(item, 1'b0, '0, draw_gap());
      end
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic watch_progress();
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1) idle = 0;
         else idle++;
      end
      timed_out = 1'b1;
      $error("no transaction for %0d cycles", STALL_LIMIT);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endtask

   task automatic compare_rsp(input rsp_type want, input rsp_type got);
      check_field("read_data", 32'(want.read_data), 32'(got.read_data));
      check_field("hit", 32'(want.hit), 32'(got.hit));
      check_field("memory_read", 32'(want.memory_read), 32'(got.memory_read));
      check_field("writeback_valid", 32'(want.writeback_valid),
                  32'(got.writeback_valid));
      check_field("writeback_address", 32'(want.writeback_address),
                  32'(got.writeback_address));
      check_field("writeback_data", 32'(want.writeback_data), 32'(got.writeback_data));
      check_field("hit_total", want.hit_total, got.hit_total);
      check_field("miss_total", want.miss_total, got.miss_total);
      check_field("memory_read_total", want.memory_read_total, got.memory_read_total);
      check_field("memory_write_total", want.memory_write_total, got.memory_write_total);
   endtask

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         if (results_due.size() == 0) begin
            $error("response with no transaction outstanding");
            failures++;
         end else begin
            compare_rsp(results_due.pop_front(), rsp_item);
         end
      end
   end

   initial begin
      reset_shadow();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      fork
         run_accesses();
         watch_progress();
      join_any
      disable fork;
      if (results_due.size() != 0) begin
         $error("%0d responses never arrived", results_due.size());
         failures++;
      end
      if (!timed_out && failures == 0) begin
         $display("direct_mapped_write_back_cache_core_test OK");
      end else begin
         $display("direct_mapped_write_back_cache_core_test NOT OK");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hdl
hdl/dmc_pkg.sv
hdl/dmc_ctrl.sv
hdl/dmc_datapath.sv
hdl/direct_mapped_write_back_cache_core.sv
tb/direct_mapped_write_back_cache_core_test.sv
